FILE: rtl/core/kwbq_pkg.sv
// kwbq_pkg: shared types, constants and arithmetic helpers of the k-weighting filter
package kwbq_pkg;

   localparam int SampleW  = 24;
   localparam int DataW    = 32;
   localparam int CoefW    = 32;
   localparam int ProdW    = 64;
   localparam int AccW     = 40;
   localparam int InFields = 2;
   localparam int StepW    = 4;
   localparam int AddrW    = 5;
   localparam int RegIdxW  = 3;

   // register indexes
   localparam logic [RegIdxW-1:0] REG_SHELF_B0      = 3'd0;
   localparam logic [RegIdxW-1:0] REG_SHELF_B1      = 3'd1;
   localparam logic [RegIdxW-1:0] REG_SHELF_B2      = 3'd2;
   localparam logic [RegIdxW-1:0] REG_SHELF_A1      = 3'd3;
   localparam logic [RegIdxW-1:0] REG_SHELF_A2      = 3'd4;
   localparam logic [RegIdxW-1:0] REG_HIGHPASS_GAIN = 3'd5;
   localparam logic [RegIdxW-1:0] REG_HIGHPASS_A1   = 3'd6;
   localparam logic [RegIdxW-1:0] REG_HIGHPASS_A2   = 3'd7;

   // tap schedule of a lane, one product per step
   localparam logic [StepW-1:0] STEP_SB0  = 4'd0;
   localparam logic [StepW-1:0] STEP_SB1  = 4'd1;
   localparam logic [StepW-1:0] STEP_SB2  = 4'd2;
   localparam logic [StepW-1:0] STEP_SA1  = 4'd3;
   localparam logic [StepW-1:0] STEP_SA2  = 4'd4;
   localparam logic [StepW-1:0] STEP_HX1  = 4'd5;
   localparam logic [StepW-1:0] STEP_HX2  = 4'd6;
   localparam logic [StepW-1:0] STEP_HA1  = 4'd7;
   localparam logic [StepW-1:0] STEP_HA2  = 4'd8;
   localparam logic [StepW-1:0] STEP_HS   = 4'd9;
   localparam logic [StepW-1:0] STEP_LAST = 4'd11;

   typedef enum logic {
      KWBQ_IDLE,
      KWBQ_BUSY
   } kwbq_state_type;

   typedef struct packed {
      logic signed [SampleW-1:0] left_sample;
      logic signed [SampleW-1:0] right_sample;
   } kwbq_req_type;

   typedef struct packed {
      logic signed [DataW-1:0] left_weighted;
      logic signed [DataW-1:0] right_weighted;
   } kwbq_rsp_type;

   typedef struct packed {
      logic signed [CoefW-1:0] shelf_b0;
      logic signed [CoefW-1:0] shelf_b1;
      logic signed [CoefW-1:0] shelf_b2;
      logic signed [CoefW-1:0] shelf_a1;
      logic signed [CoefW-1:0] shelf_a2;
      logic signed [CoefW-1:0] highpass_gain;
      logic signed [CoefW-1:0] highpass_a1;
      logic signed [CoefW-1:0] highpass_a2;
   } kwbq_coef_type;

   typedef struct packed {
      logic             start;
      logic             mul_en;
      logic             commit;
      logic [StepW-1:0] step;
   } kwbq_ctrl_type;

   // 48 kHz coefficients
   localparam kwbq_coef_type CoefReset = '{
      shelf_b0:      32'sd412081942,
      shelf_b1:      -32'sd722546694,
      shelf_b2:      32'sd321691120,
      shelf_a1:      -32'sd453832899,
      shelf_a2:      32'sd196623811,
      highpass_gain: 32'sd268435456,
      highpass_a1:   -32'sd534199295,
      highpass_a2:   32'sd265770496
   };

   localparam logic signed [ProdW-1:0] RndHalf28 = 64'sh0000_0000_0800_0000;
   localparam logic signed [ProdW-1:0] RndHalf27 = 64'sh0000_0000_0400_0000;

   // round a q28 product to q23, half up; sh27 rounds one bit less for the -2 tap
   function automatic logic signed [AccW-1:0] kwbq_round(
      input logic signed [ProdW-1:0] p,
      input logic                    sh27
   );
      logic signed [ProdW-1:0] sum;
      logic signed [ProdW-1:0] shifted;
      sum     = p + (sh27 ? RndHalf27 : RndHalf28);
      shifted = sh27 ? (sum >>> 27) : (sum >>> 28);
      return shifted[AccW-1:0];
   endfunction

   function automatic logic signed [DataW-1:0] kwbq_sat(
      input logic signed [AccW-1:0] v
   );
      logic [AccW-DataW:0] top;
      top = v[AccW-1:DataW-1];
      if ((&top) || !(|top)) begin
         return v[DataW-1:0];
      end else if (v[AccW-1]) begin
         return {1'b1, {(DataW-1){1'b0}}};
      end else begin
         return {1'b0, {(DataW-1){1'b1}}};
      end
   endfunction

endpackage

FILE: rtl/core/k_weighting_biquad_filter_core.sv
// k_weighting_biquad_filter_core: stereo k-weighting pre-filter top level
// Each channel has its own lane with one 32x32 multiplier that walks the ten
// taps of the shelf and high-pass biquads, one product per cycle, with a
// rounding accumulate in the cycle after each product. A request is taken
// only while the lanes are idle; its result is written to the output register
// when the lanes commit at their last step, and the lanes go idle with that
// commit, so a new request is not taken before the last one is through. The
// result register frees the lanes while a result waits; a stalled result holds
// the lanes at their last step until the register is free.
module k_weighting_biquad_filter_core #(
   parameter int CHANNELS = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  kwbq_pkg::kwbq_req_type      req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output kwbq_pkg::kwbq_rsp_type      rsp_data,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [kwbq_pkg::AddrW-1:0]  csr_paddr,
   input  logic [kwbq_pkg::CoefW-1:0]  csr_pwdata,
   output logic [kwbq_pkg::CoefW-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import kwbq_pkg::*;

   localparam int Lanes = (CHANNELS < InFields) ? CHANNELS : InFields;

   kwbq_state_type          state_ff, state_in;
   logic [StepW-1:0]        step_ff, step_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   kwbq_rsp_type            rsp_data_ff, rsp_data_in;
   kwbq_ctrl_type           ctrl;
   kwbq_coef_type           coef;
   logic                    accept;
   logic                    commit;
   logic signed [DataW-1:0] lane_y [Lanes];

   kwbq_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef)
   );

   for (genvar c = 0; c < Lanes; c++) begin : g_lane
      logic signed [SampleW-1:0] lane_x;
      if (c == 0) begin : g_left
         assign lane_x = req_data.left_sample;
      end else begin : g_right
         assign lane_x = req_data.right_sample;
      end
      kwbq_lane u_lane (
         .clock (clock),
         .reset (reset),
         .ctrl  (ctrl),
         .coef  (coef),
         .x     (lane_x),
         .y     (lane_y[c])
      );
   end

   assign accept = req_valid && !req_stall;
   assign commit = (state_ff == KWBQ_BUSY) && (step_ff == STEP_LAST) &&
                   (!rsp_valid_ff || !rsp_stall);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         KWBQ_IDLE: if (accept) state_in = KWBQ_BUSY;
         KWBQ_BUSY: if (commit) state_in = KWBQ_IDLE;
         default:               state_in = KWBQ_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall   = 1'b1;
      ctrl.start  = 1'b0;
      ctrl.mul_en = 1'b0;
      ctrl.commit = 1'b0;
      ctrl.step   = step_ff;
      step_in     = step_ff;
      unique case (state_ff)
         KWBQ_IDLE: begin
            req_stall  = 1'b0;
            ctrl.start = req_valid;
            step_in    = STEP_SB0;
         end
         KWBQ_BUSY: begin
            ctrl.mul_en = (step_ff <= STEP_HS);
            ctrl.commit = commit;
            if (step_ff != STEP_LAST) begin
               step_in = step_ff + 1'b1;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // merge lane results; a channel without a lane reads zero
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (commit) begin
         rsp_data_in.left_weighted  = lane_y[0];
         rsp_data_in.right_weighted = '0;
         if (Lanes > 1) begin
            rsp_data_in.right_weighted = lane_y[Lanes-1];
         end
      end
   end

   assign rsp_valid_in = commit || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      step_ff     <= step_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= KWBQ_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/core/kwbq_regs.sv
// kwbq_regs: apb coefficient registers of the k-weighting filter
module kwbq_regs (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [kwbq_pkg::AddrW-1:0]   csr_paddr,
   input  logic [kwbq_pkg::CoefW-1:0]   csr_pwdata,
   output logic [kwbq_pkg::CoefW-1:0]   csr_prdata,
   output logic                         csr_pready,
   output kwbq_pkg::kwbq_coef_type      coef
);
   import kwbq_pkg::*;

   kwbq_coef_type        coef_ff;
   kwbq_coef_type        coef_in;
   logic [RegIdxW-1:0]   idx;
   logic                 wr_en;

   assign idx        = csr_paddr[AddrW-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign coef       = coef_ff;

   always_comb begin
      coef_in = coef_ff;
      if (wr_en) begin
         unique case (idx)
            REG_SHELF_B0:      coef_in.shelf_b0      = csr_pwdata;
            REG_SHELF_B1:      coef_in.shelf_b1      = csr_pwdata;
            REG_SHELF_B2:      coef_in.shelf_b2      = csr_pwdata;
            REG_SHELF_A1:      coef_in.shelf_a1      = csr_pwdata;
            REG_SHELF_A2:      coef_in.shelf_a2      = csr_pwdata;
            REG_HIGHPASS_GAIN: coef_in.highpass_gain = csr_pwdata;
            REG_HIGHPASS_A1:   coef_in.highpass_a1   = csr_pwdata;
            REG_HIGHPASS_A2:   coef_in.highpass_a2   = csr_pwdata;
            default:           coef_in               = coef_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_SHELF_B0:      csr_prdata = coef_ff.shelf_b0;
         REG_SHELF_B1:      csr_prdata = coef_ff.shelf_b1;
         REG_SHELF_B2:      csr_prdata = coef_ff.shelf_b2;
         REG_SHELF_A1:      csr_prdata = coef_ff.shelf_a1;
         REG_SHELF_A2:      csr_prdata = coef_ff.shelf_a2;
         REG_HIGHPASS_GAIN: csr_prdata = coef_ff.highpass_gain;
         REG_HIGHPASS_A1:   csr_prdata = coef_ff.highpass_a1;
         REG_HIGHPASS_A2:   csr_prdata = coef_ff.highpass_a2;
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= CoefReset;
      end else begin
         coef_ff <= coef_in;
      end
   end

endmodule

FILE: rtl/core/kwbq_lane.sv
// kwbq_lane: one channel of shelf and high-pass biquads on a shared multiplier
module kwbq_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  kwbq_pkg::kwbq_ctrl_type             ctrl,
   input  kwbq_pkg::kwbq_coef_type             coef,
   input  logic signed [kwbq_pkg::SampleW-1:0] x,
   output logic signed [kwbq_pkg::DataW-1:0]   y
);
   import kwbq_pkg::*;

   logic signed [DataW-1:0] x_ff;
   logic signed [DataW-1:0] sx1_ff, sx2_ff, sy1_ff, sy2_ff;
   logic signed [DataW-1:0] hx1_ff, hx2_ff, hy1_ff, hy2_ff;
   logic signed [AccW-1:0]  shelf_acc_ff, shelf_acc_in;
   logic signed [AccW-1:0]  hp_acc_ff, hp_acc_in;
   logic signed [ProdW-1:0] prod_ff, prod_in;
   logic                    prod_neg_ff, prod_neg_in;
   logic                    prod_sh27_ff, prod_sh27_in;
   logic                    prod_hp_ff, prod_hp_in;
   logic                    prod_vld_ff;
   logic signed [CoefW-1:0] op_coef;
   logic signed [DataW-1:0] op_data;
   logic signed [DataW-1:0] shelf_out;
   logic signed [AccW-1:0]  term;

   assign shelf_out = kwbq_sat(shelf_acc_ff);
   assign y         = kwbq_sat(hp_acc_ff);

   // operand select for the current tap
   always_comb begin
      op_coef      = '0;
      op_data      = '0;
      prod_neg_in  = 1'b0;
      prod_sh27_in = 1'b0;
      prod_hp_in   = 1'b0;
      case (ctrl.step)
         STEP_SB0: begin
            op_coef = coef.shelf_b0;
            op_data = x_ff;
         end
         STEP_SB1: begin
            op_coef = coef.shelf_b1;
            op_data = sx1_ff;
         end
         STEP_SB2: begin
            op_coef = coef.shelf_b2;
            op_data = sx2_ff;
         end
         STEP_SA1: begin
            op_coef     = coef.shelf_a1;
            op_data     = sy1_ff;
            prod_neg_in = 1'b1;
         end
         STEP_SA2: begin
            op_coef     = coef.shelf_a2;
            op_data     = sy2_ff;
            prod_neg_in = 1'b1;
         end
         STEP_HX1: begin
            op_coef      = coef.highpass_gain;
            op_data      = hx1_ff;
            prod_neg_in  = 1'b1;
            prod_sh27_in = 1'b1;
            prod_hp_in   = 1'b1;
         end
         STEP_HX2: begin
            op_coef    = coef.highpass_gain;
            op_data    = hx2_ff;
            prod_hp_in = 1'b1;
         end
         STEP_HA1: begin
            op_coef     = coef.highpass_a1;
            op_data     = hy1_ff;
            prod_neg_in = 1'b1;
            prod_hp_in  = 1'b1;
         end
         STEP_HA2: begin
            op_coef     = coef.highpass_a2;
            op_data     = hy2_ff;
            prod_neg_in = 1'b1;
            prod_hp_in  = 1'b1;
         end
         STEP_HS: begin
            // shelf sum has settled by this step
            op_coef    = coef.highpass_gain;
            op_data    = shelf_out;
            prod_hp_in = 1'b1;
         end
         default: begin
            op_coef = '0;
            op_data = '0;
         end
      endcase
   end

   assign prod_in = op_coef * op_data;
   assign term    = kwbq_round(prod_ff, prod_sh27_ff);

   always_comb begin
      shelf_acc_in = shelf_acc_ff;
      hp_acc_in    = hp_acc_ff;
      if (ctrl.start) begin
         shelf_acc_in = '0;
         hp_acc_in    = '0;
      end else if (prod_vld_ff) begin
         if (prod_hp_ff) begin
            hp_acc_in = prod_neg_ff ? hp_acc_ff - term : hp_acc_ff + term;
         end else begin
            shelf_acc_in = prod_neg_ff ? shelf_acc_ff - term : shelf_acc_ff + term;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff      <= prod_in;
      prod_neg_ff  <= prod_neg_in;
      prod_sh27_ff <= prod_sh27_in;
      prod_hp_ff   <= prod_hp_in;
      shelf_acc_ff <= shelf_acc_in;
      hp_acc_ff    <= hp_acc_in;
      if (ctrl.start) begin
         x_ff <= DataW'(x);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         sx1_ff      <= '0;
         sx2_ff      <= '0;
         sy1_ff      <= '0;
         sy2_ff      <= '0;
         hx1_ff      <= '0;
         hx2_ff      <= '0;
         hy1_ff      <= '0;
         hy2_ff      <= '0;
      end else begin
         prod_vld_ff <= ctrl.mul_en;
         if (ctrl.commit) begin
            sx2_ff <= sx1_ff;
            sx1_ff <= x_ff;
            sy2_ff <= sy1_ff;
            sy1_ff <= shelf_out;
            hx2_ff <= hx1_ff;
            hx1_ff <= shelf_out;
            hy2_ff <= hy1_ff;
            hy1_ff <= y;
         end
      end
   end

endmodule

FILE: rtl/core/kwbq_checker.sv
// kwbq_checker: port-level assertions of the k-weighting filter, bound to the top level
module kwbq_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall
);

   // a request keeps the lanes busy for the following cycle
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted but input side not busy next cycle");

   // results come only out of a busy period
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a request in flight");

   // the lanes free up only by handing a result to the output register
   a_free_with_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(req_stall) |-> rsp_valid)
      else $error("input side freed without a result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result dropped");

endmodule

bind k_weighting_biquad_filter_core kwbq_checker u_kwbq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall)
);

FILE: sim/testbench.sv
// testbench: self-checking bench for the stereo k-weighting biquad filter core
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import kwbq_pkg::*;

   localparam int HalfPeriod   = 4;
   localparam int Lanes        = 2;
   localparam int NumRegs      = 8;
   localparam int SettleCycles = 20;
   localparam int BatchSize    = 32;
   localparam int IdlePct      = 38;

   typedef enum {
      SET_48K,
      SET_NUDGED,
      SET_RANDOM,
      SET_FIR,
      SET_ALL_MAX,
      SET_ALL_MIN,
      SET_MIXED
   } coef_set_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   kwbq_req_type        req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   kwbq_rsp_type        rsp_data;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [AddrW-1:0]    csr_paddr = '0;
   logic [CoefW-1:0]    csr_pwdata = '0;
   logic [CoefW-1:0]    csr_prdata;
   logic                csr_pready;

   // 48 kHz coefficient set, q4.28
   longint coef_48k [NumRegs] = '{412081942, -722546694, 321691120, -453832899,
                                  196623811, 268435456, -534199295, 265770496};
   longint tap_coef [NumRegs];

   // filter history per channel, q9.23
   longint shelf_x1 [Lanes];
   longint shelf_x2 [Lanes];
   longint shelf_y1 [Lanes];
   longint shelf_y2 [Lanes];
   longint hipass_x1 [Lanes];
   longint hipass_x2 [Lanes];
   longint hipass_y1 [Lanes];
   longint hipass_y2 [Lanes];

   kwbq_req_type sample_backlog [$];
   kwbq_rsp_type weighted_due [$];

   int error_count    = 0;
   int accepted_count = 0;
   int checked_count  = 0;
   int clipped_count  = 0;
   int coef_set_count = 0;
   int csr_read_count = 0;
   int send_gap_pct   = IdlePct;
   int stall_pct      = IdlePct;

   k_weighting_biquad_filter_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(HalfPeriod) clock = ~clock;

   // q28 product to q23, half rounds up
   function automatic longint round_q(input longint p, input int sh);
      return (p + (longint'(1) <<< (sh - 1))) >>> sh;
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) begin
         clipped_count++;
         return 64'sd2147483647;
      end else if (v < -64'sd2147483648) begin
         clipped_count++;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // shelf then high pass for one channel, advancing its history
   function automatic logic signed [DataW-1:0] weigh_channel(
      input int                         ch,
      input logic signed [SampleW-1:0]  sample
   );
      longint x, s, h, g;
      x = sample;
      g = tap_coef[REG_HIGHPASS_GAIN];
      s = round_q(tap_coef[REG_SHELF_B0] * x, 28)
        + round_q(tap_coef[REG_SHELF_B1] * shelf_x1[ch], 28)
        + round_q(tap_coef[REG_SHELF_B2] * shelf_x2[ch], 28)
        - round_q(tap_coef[REG_SHELF_A1] * shelf_y1[ch], 28)
        - round_q(tap_coef[REG_SHELF_A2] * shelf_y2[ch], 28);
      s = clamp32(s);
      shelf_x2[ch] = shelf_x1[ch];
      shelf_x1[ch] = x;
      shelf_y2[ch] = shelf_y1[ch];
      shelf_y1[ch] = s;
      // the -2 tap is one less bit of shift on g*x1
      h = round_q(g * s, 28)
        - round_q(g * hipass_x1[ch], 27)
        + round_q(g * hipass_x2[ch], 28)
        - round_q(tap_coef[REG_HIGHPASS_A1] * hipass_y1[ch], 28)
        - round_q(tap_coef[REG_HIGHPASS_A2] * hipass_y2[ch], 28);
      h = clamp32(h);
      hipass_x2[ch] = hipass_x1[ch];
      hipass_x1[ch] = s;
      hipass_y2[ch] = hipass_y1[ch];
      hipass_y1[ch] = h;
      return h[DataW-1:0];
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      error_count++;
      if (error_count <= 10) begin
         $display("mismatch %s: expected %0d, got %0d", what, $signed(want), $signed(got));
      end
   endtask

   // request driver
   always @(posedge clock) begin
      kwbq_rsp_type weighted;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            weighted.left_weighted  = weigh_channel(0, req_data.left_sample);
            weighted.right_weighted = weigh_channel(1, req_data.right_sample);
            weighted_due = {weighted_due, weighted};
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (sample_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               req_valid <= 1'b1;
               req_data  <= sample_backlog[0];
               sample_backlog.delete(0);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      kwbq_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (weighted_due.size() == 0) begin
               flag_mismatch("result with no request pending", 'x, rsp_data.left_weighted);
            end else begin
               want = weighted_due[0];
               weighted_due.delete(0);
               if (rsp_data.left_weighted !== want.left_weighted) begin
                  flag_mismatch($sformatf("left_weighted of result %0d", checked_count),
                                want.left_weighted, rsp_data.left_weighted);
               end
               if (rsp_data.right_weighted !== want.right_weighted) begin
                  flag_mismatch($sformatf("right_weighted of result %0d", checked_count),
                                want.right_weighted, rsp_data.right_weighted);
               end
            end
            checked_count++;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // setup and access phases, then idle; entered just after a rising edge
   task automatic csr_write(input logic [RegIdxW-1:0] idx, input logic [31:0] word);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      tap_coef[idx] = longint'(signed'(word));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read_check(input logic [RegIdxW-1:0] idx);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== tap_coef[idx][31:0]) begin
         flag_mismatch($sformatf("readback of register %0d", idx), tap_coef[idx][31:0],
                       csr_prdata);
      end
      csr_read_count++;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_coefs(input coef_set_type kind);
      logic [31:0] word;
      int i;
      for (i = 0; i < NumRegs; i++) begin
         case (kind)
            SET_48K: word = coef_48k[i][31:0];
            SET_NUDGED: word = coef_48k[i][31:0] + ($urandom_range(0, 2**21) - 2**20);
            SET_RANDOM: word = $urandom;
            SET_FIR: begin
               if (i == REG_SHELF_A1 || i == REG_SHELF_A2 || i == REG_HIGHPASS_A1
                   || i == REG_HIGHPASS_A2) begin
                  word = '0;
               end else begin
                  word = $urandom;
               end
            end
            SET_ALL_MAX: word = 32'h7fff_ffff;
            SET_ALL_MIN: word = 32'h8000_0000;
            default: begin
               // strongest positive feed-forward, strongest negative feedback
               if (i == REG_SHELF_A1 || i == REG_SHELF_A2 || i == REG_HIGHPASS_A1
                   || i == REG_HIGHPASS_A2) begin
                  word = 32'h8000_0000;
               end else begin
                  word = 32'h7fff_ffff;
               end
            end
         endcase
         csr_write(RegIdxW'(i), word);
      end
      for (i = 0; i < NumRegs; i++) begin
         csr_read_check(RegIdxW'(i));
      end
      coef_set_count++;
   endtask

   // wait for every expected result, then let the lanes go quiet
   task automatic settle();
      @(negedge clock);
      while (sample_backlog.size() != 0 || req_valid || weighted_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic queue_pair(input logic [SampleW-1:0] left, input logic [SampleW-1:0] right);
      kwbq_req_type pair;
      pair.left_sample  = left;
      pair.right_sample = right;
      sample_backlog = {sample_backlog, pair};
   endtask

   function automatic logic signed [SampleW-1:0] pick_sample(
      input logic signed [SampleW-1:0] prev
   );
      case ($urandom_range(9))
         0: return 24'h7f_ffff;
         1: return 24'h80_0000;
         2, 3: return prev;
         4, 5: return SampleW'($urandom_range(0, 1023)) - 24'd512;
         default: return SampleW'($urandom);
      endcase
   endfunction

   task automatic queue_random(input int count);
      kwbq_req_type pair = '0;
      int n;
      for (n = 0; n < count; n++) begin
         pair.left_sample = pick_sample(pair.left_sample);
         if ($urandom_range(7) == 0) begin
            pair.right_sample = pair.left_sample;
         end else begin
            pair.right_sample = pick_sample(pair.right_sample);
         end
         sample_backlog = {sample_backlog, pair};
      end
   endtask

   initial begin
      coef_set_type rand_kinds [6];
      int p, i;
      rand_kinds = '{SET_48K, SET_NUDGED, SET_RANDOM, SET_FIR, SET_NUDGED, SET_48K};
      for (i = 0; i < NumRegs; i++) begin
         tap_coef[i] = coef_48k[i];
      end
      for (i = 0; i < Lanes; i++) begin
         shelf_x1[i] = 0;
         shelf_x2[i] = 0;
         shelf_y1[i] = 0;
         shelf_y2[i] = 0;
         hipass_x1[i] = 0;
         hipass_x2[i] = 0;
         hipass_y1[i] = 0;
         hipass_y2[i] = 0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (i = 0; i < NumRegs; i++) begin
         csr_read_check(RegIdxW'(i));
      end

      // 48 kHz set: steps, full-scale alternation, impulses, unit values
      queue_pair(24'h00_0000, 24'h00_0000);
      queue_pair(24'h7f_ffff, 24'h80_0000);
      queue_pair(24'h7f_ffff, 24'h80_0000);
      queue_pair(24'h7f_ffff, 24'h80_0000);
      queue_pair(24'h80_0000, 24'h7f_ffff);
      queue_pair(24'h7f_ffff, 24'h80_0000);
      queue_pair(24'h80_0000, 24'h7f_ffff);
      queue_pair(24'h7f_ffff, 24'h80_0000);
      queue_pair(24'h00_0001, 24'hff_ffff);
      queue_pair(24'h00_0000, 24'h00_0000);
      queue_pair(24'h00_0000, 24'h00_0000);
      queue_pair(24'hff_ffff, 24'h00_0001);
      queue_pair(24'h00_0000, 24'h00_0000);
      settle();

      // extreme coefficients drive both stages into saturation
      load_coefs(SET_ALL_MAX);
      queue_pair(24'h7f_ffff, 24'h80_0000);
      queue_pair(24'h80_0000, 24'h7f_ffff);
      queue_pair(24'h00_0001, 24'hff_ffff);
      queue_pair(24'h00_0000, 24'h00_0000);
      settle();
      load_coefs(SET_ALL_MIN);
      queue_pair(24'h7f_ffff, 24'h80_0000);
      queue_pair(24'h80_0000, 24'h7f_ffff);
      queue_pair(24'h00_0001, 24'hff_ffff);
      queue_pair(24'h00_0000, 24'h00_0000);
      settle();
      load_coefs(SET_MIXED);
      queue_pair(24'h7f_ffff, 24'h7f_ffff);
      queue_pair(24'h80_0000, 24'h80_0000);
      queue_pair(24'h00_0000, 24'h00_0000);
      settle();

      for (p = 0; p < 6; p++) begin
         load_coefs(rand_kinds[p]);
         if (p == 4) begin
            send_gap_pct = 0;
            stall_pct    = 0;
         end
         queue_random(BatchSize);
         if (p == 1) begin
            // hold the sender until the pipe is empty, same coefficients after
            settle();
         end
         queue_random(BatchSize);
         settle();
         send_gap_pct = IdlePct;
         stall_pct    = IdlePct;
      end

      $display("checked %0d filtered stereo results for %0d requests over %0d coefficient sets",
               checked_count, accepted_count, coef_set_count);
      $display("%0d stage outputs hit the rails; %0d register reads compared",
               clipped_count, csr_read_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
